### sv/aorf_pkg.sv
// Shared types, constants and the circular distance check for the angle outlier filter.
package aorf_pkg;

  localparam int ANG_W = 9;
  localparam int TOL_W = 8;
  localparam logic [ANG_W-1:0] MAX_ANGLE   = 9'd359;
  localparam logic [ANG_W:0]   FULL_CIRCLE = 10'd360;
  localparam logic [ANG_W-1:0] HALF_CIRCLE = 9'd180;
  localparam logic [TOL_W-1:0] TOL_RESET   = 8'd15;

  typedef logic [ANG_W-1:0] angle_t;

  // Control broadcast to every cell of the window chain.
  typedef struct packed {
    logic                shift;
    logic                fix;
    angle_t              wr_angle;
    angle_t              center;
    logic [TOL_W-1:0]    tol;
  } cell_ctl_t;

  function automatic logic within_reach(input angle_t a, input angle_t b,
                                        input logic [TOL_W-1:0] tol);
    angle_t       d;
    logic [ANG_W:0] wrap;
    d = (a > b) ? (a - b) : (b - a);
    wrap = FULL_CIRCLE - {1'b0, d};
    if (d > HALF_CIRCLE) begin
      d = wrap[ANG_W-1:0];
    end
    return d <= {1'b0, tol};
  endfunction

endpackage

### sv/aorf_cell.sv
// One window cell: holds an angle, shifts left, compares against the center angle.
module aorf_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 3,
  parameter int HALF  = 3
) (
  input  logic              clk,
  input  aorf_pkg::cell_ctl_t ctl,
  input  logic              wr,
  input  logic [IDX_W-1:0]  pos,
  input  aorf_pkg::angle_t  left_val,
  input  aorf_pkg::angle_t  right_corr,
  output aorf_pkg::angle_t  val,
  output aorf_pkg::angle_t  corr,
  output aorf_pkg::angle_t  sel_val,
  output aorf_pkg::angle_t  sel_left,
  output logic              sel,
  output logic              near
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [IDX_W:0]   HALF_V = (IDX_W+1)'(HALF);

  aorf_pkg::angle_t val_r;
  aorf_pkg::angle_t val_nxt;
  logic [IDX_W-1:0] idx_gap;
  logic             in_range;

  assign sel      = (pos == MY_IDX);
  assign idx_gap  = (MY_IDX > pos) ? (MY_IDX - pos) : (pos - MY_IDX);
  assign in_range = !sel && ({1'b0, idx_gap} <= HALF_V);
  assign near     = in_range && aorf_pkg::within_reach(ctl.center, val_r, ctl.tol);
  assign val      = val_r;
  assign corr     = (ctl.fix && sel) ? left_val : val_r;
  assign sel_val  = sel ? val_r : '0;
  assign sel_left = sel ? left_val : '0;

  always_comb begin
    val_nxt = corr;
    if (wr) begin
      val_nxt = ctl.wr_angle;
    end else if (ctl.shift) begin
      val_nxt = right_corr;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### sv/angle_outlier_replace_filter.sv
// Top level: angle outlier replacement over a sliding window built as a chain of cells.
//
//   channel  direction  ports
//   in       sink       in_valid, in_stall, in_angle_in, in_last_in_block
//   out      source     out_valid, out_stall, out_angle_out, out_replaced, out_last_out
//   cfg      sink       cfg_wr_en, cfg_wr_data (tolerance)
//
// Steady state: one transfer per cycle; the center cell is judged while the next angle shifts in.
// Window fill completion: HALF_WINDOW+1 results, input stalled until the last of them is judged.
// Block end: flush of the remaining results, one per cycle from the output register.
// Output stall holds the judging sequencer and therefore the input.
// rst_n is synchronous; it clears fill count, sequencer and tolerance (to 15).
module angle_outlier_replace_filter #(
  parameter int HALF_WINDOW = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [aorf_pkg::ANG_W-1:0] in_angle_in,
  input  logic                       in_last_in_block,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [aorf_pkg::ANG_W-1:0] out_angle_out,
  output logic                       out_replaced,
  output logic                       out_last_out,
  input  logic                       cfg_wr_en,
  input  logic [aorf_pkg::TOL_W-1:0] cfg_wr_data
);

  localparam int W      = 2 * HALF_WINDOW + 1;
  localparam int IDX_W  = $clog2(W);
  localparam int FILL_W = $clog2(W + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(W);
  localparam logic [IDX_W-1:0]  POS_HALF  = IDX_W'(HALF_WINDOW);
  localparam logic [IDX_W-1:0]  POS_LAST  = IDX_W'(W - 1);

  logic [aorf_pkg::TOL_W-1:0] tol_r;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic                       busy_r, busy_nxt;
  logic [IDX_W-1:0]           pos_r, pos_nxt;
  logic [IDX_W-1:0]           end_r, end_nxt;
  logic                       judge_r, judge_nxt;
  logic                       endlast_r, endlast_nxt;
  logic                       out_valid_r;
  aorf_pkg::angle_t           out_angle_r;
  logic                       out_replaced_r;
  logic                       out_last_r;

  aorf_pkg::angle_t    in_sat;
  aorf_pkg::cell_ctl_t ctl;
  aorf_pkg::angle_t    val    [W];
  aorf_pkg::angle_t    corr   [W];
  aorf_pkg::angle_t    sval   [W];
  aorf_pkg::angle_t    sleft  [W];
  logic [W-1:0]        sel;
  logic [W-1:0]        near;
  logic [W-1:0]        wr;
  aorf_pkg::angle_t    center;
  aorf_pkg::angle_t    repl;
  logic                accept;
  logic                fire;
  logic                rep;
  logic                last_step;

  assign in_sat = (in_angle_in > aorf_pkg::MAX_ANGLE) ? aorf_pkg::MAX_ANGLE : in_angle_in;
  assign accept = in_valid && !in_stall;
  assign fire   = busy_r && (!out_valid_r || !out_stall);
  assign last_step = (pos_r == end_r);
  assign in_stall  = busy_r && !(fire && last_step && !endlast_r);

  always_comb begin
    center = '0;
    repl   = '0;
    for (int i = 0; i < W; i++) begin
      center = center | sval[i];
      repl   = repl | sleft[i];
    end
  end

  assign rep = judge_r && !(|near);

  always_comb begin
    ctl.shift    = accept && (fill_r == FILL_FULL);
    ctl.fix      = fire && rep;
    ctl.wr_angle = in_sat;
    ctl.center   = center;
    ctl.tol      = tol_r;
  end

  always_comb begin
    for (int i = 0; i < W; i++) begin
      wr[i] = accept && (fill_r < FILL_FULL) && (fill_r[IDX_W-1:0] == IDX_W'(i));
    end
  end

  for (genvar g = 0; g < W; g++) begin : g_cell
    aorf_pkg::angle_t left_v;
    aorf_pkg::angle_t right_v;
    if (g == 0) begin : g_first
      assign left_v = val[1];
    end else begin : g_mid
      assign left_v = val[g-1];
    end
    if (g == W - 1) begin : g_tail
      assign right_v = in_sat;
    end else begin : g_body
      assign right_v = corr[g+1];
    end
    aorf_cell #(
      .IDX  (g),
      .IDX_W(IDX_W),
      .HALF (HALF_WINDOW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr        (wr[g]),
      .pos       (pos_r),
      .left_val  (left_v),
      .right_corr(right_v),
      .val       (val[g]),
      .corr      (corr[g]),
      .sel_val   (sval[g]),
      .sel_left  (sleft[g]),
      .sel       (sel[g]),
      .near      (near[g])
    );
  end

  // Sequencer: a transfer sets up the next run of cells to judge or pass.
  always_comb begin
    fill_nxt    = fill_r;
    busy_nxt    = busy_r;
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    judge_nxt   = judge_r;
    endlast_nxt = endlast_r;
    if (fire) begin
      pos_nxt = pos_r + 1'b1;
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
    if (accept) begin
      if (in_last_in_block) begin
        fill_nxt = '0;
      end else if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
      if (fill_r == FILL_FULL) begin
        busy_nxt    = 1'b1;
        pos_nxt     = POS_HALF;
        end_nxt     = in_last_in_block ? POS_LAST : POS_HALF;
        judge_nxt   = 1'b1;
        endlast_nxt = in_last_in_block;
      end else if (fill_r == FILL_FULL - 1'b1) begin
        busy_nxt    = 1'b1;
        pos_nxt     = '0;
        end_nxt     = in_last_in_block ? POS_LAST : POS_HALF;
        judge_nxt   = 1'b1;
        endlast_nxt = in_last_in_block;
      end else if (in_last_in_block) begin
        busy_nxt    = 1'b1;
        pos_nxt     = '0;
        end_nxt     = fill_r[IDX_W-1:0];
        judge_nxt   = 1'b0;
        endlast_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= aorf_pkg::TOL_RESET;
      fill_r      <= '0;
      busy_r      <= 1'b0;
      pos_r       <= '0;
      end_r       <= '0;
      judge_r     <= 1'b0;
      endlast_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol_r <= cfg_wr_data;
      end
      fill_r    <= fill_nxt;
      busy_r    <= busy_nxt;
      pos_r     <= pos_nxt;
      end_r     <= end_nxt;
      judge_r   <= judge_nxt;
      endlast_r <= endlast_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_angle_r    <= rep ? repl : center;
      out_replaced_r <= rep;
      out_last_r     <= endlast_r && last_step;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_angle_out = out_angle_r;
  assign out_replaced  = out_replaced_r;
  assign out_last_out  = out_last_r;

`ifndef SYNTHESIS
  a_pos_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pos_r <= end_r))
    else $error("run pointer beyond run end");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond window length");
  a_one_center: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel))
    else $error("more than one center cell");
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_in_block) |=> (busy_r && endlast_r && fill_r == '0))
    else $error("block end did not start a flush");
`endif

endmodule

### verif/angle_outlier_replace_filter_test.sv
// Self-checking testbench for angle_outlier_replace_filter: directed and random angle blocks.
`timescale 1ns / 100ps

module angle_outlier_replace_filter_test;

  localparam int HALF = 3;
  localparam int WIN_LEN = 2 * HALF + 1;
  localparam int CYCLE_LIMIT = 50000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD_AT = 60;
  localparam int LONG_HOLD_CYCLES = 80;

  typedef logic [aorf_pkg::TOL_W-1:0] tol_t;

  typedef struct {
    aorf_pkg::angle_t angle;
    logic             replaced;
    logic             last;
  } filt_result_t;

  class angle_filter_scoreboard;
    aorf_pkg::angle_t win[WIN_LEN];
    int               fill;
    tol_t             tol;
    filt_result_t     pending_results[$];
    int               errors;

    function new();
      fill = 0;
      tol = aorf_pkg::TOL_RESET;
      errors = 0;
    endfunction

    function void set_tolerance(tol_t t);
      tol = t;
    endfunction

    function bit close_enough(aorf_pkg::angle_t a, aorf_pkg::angle_t b);
      int ia, ib, d;
      ia = int'(a);
      ib = int'(b);
      d = (ia > ib) ? ia - ib : ib - ia;
      if (d > 180) d = 360 - d;
      return d <= int'(tol);
    endfunction

    // judge window entry c, correcting it in place when no neighbor supports it
    function logic judge_center(int c, int n);
      int lo, hi;
      lo = (c >= HALF) ? c - HALF : 0;
      hi = (c + HALF < n) ? c + HALF : n - 1;
      for (int k = lo; k <= hi; k++) begin
        if (k != c && close_enough(win[c], win[k])) return 1'b0;
      end
      win[c] = (c == 0) ? win[1] : win[c-1];
      return 1'b1;
    endfunction

    function void expect_result(aorf_pkg::angle_t ang, logic rep, logic last);
      filt_result_t r;
      r.angle = ang;
      r.replaced = rep;
      r.last = last;
      pending_results.push_back(r);
    endfunction

    function void note_sample(aorf_pkg::angle_t raw, logic last);
      aorf_pkg::angle_t a;
      logic             rep;
      a = (raw > aorf_pkg::MAX_ANGLE) ? aorf_pkg::MAX_ANGLE : raw;
      if (fill < WIN_LEN) begin
        win[fill] = a;
        fill++;
        if (fill < WIN_LEN) begin
          if (last) begin
            for (int c = 0; c < fill; c++) expect_result(win[c], 1'b0, c + 1 == fill);
            fill = 0;
          end
          return;
        end
        if (last) begin
          for (int c = 0; c < WIN_LEN; c++) begin
            rep = judge_center(c, WIN_LEN);
            expect_result(win[c], rep, c + 1 == WIN_LEN);
          end
          fill = 0;
        end else begin
          for (int c = 0; c <= HALF; c++) begin
            rep = judge_center(c, WIN_LEN);
            expect_result(win[c], rep, 1'b0);
          end
        end
        return;
      end
      for (int k = 0; k < WIN_LEN - 1; k++) win[k] = win[k+1];
      win[WIN_LEN-1] = a;
      if (!last) begin
        rep = judge_center(HALF, WIN_LEN);
        expect_result(win[HALF], rep, 1'b0);
      end else begin
        for (int c = HALF; c < WIN_LEN; c++) begin
          rep = judge_center(c, WIN_LEN);
          expect_result(win[c], rep, c + 1 == WIN_LEN);
        end
        fill = 0;
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(aorf_pkg::angle_t ang, logic rep, logic last);
      filt_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer, angle_out", int'(ang), -1);
        return;
      end
      want = pending_results.pop_front();
      if (ang !== want.angle) report_mismatch("angle_out", int'(ang), int'(want.angle));
      if (rep !== want.replaced) report_mismatch("replaced", int'(rep), int'(want.replaced));
      if (last !== want.last) report_mismatch("last_out", int'(last), int'(want.last));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  aorf_pkg::angle_t in_angle_in = '0;
  logic             in_last_in_block = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  aorf_pkg::angle_t out_angle_out;
  logic             out_replaced;
  logic             out_last_out;
  logic             cfg_wr_en = 1'b0;
  tol_t             cfg_wr_data = '0;

  angle_filter_scoreboard filter_sb = new();
  int  sent_count = 0;
  int  cycle_count = 0;
  int  pause_at = -1;
  bit  quiet = 1'b0;

  angle_outlier_replace_filter #(.HALF_WINDOW(HALF)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle_in      (in_angle_in),
    .in_last_in_block (in_last_in_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_angle_out    (out_angle_out),
    .out_replaced     (out_replaced),
    .out_last_out     (out_last_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[angle_outlier_replace_filter] ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_sample(input aorf_pkg::angle_t ang, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_in <= ang;
    in_last_in_block <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_sb.note_sample(ang, last);
    sent_count++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (filter_sb.pending_results.size() != 0);
  endtask

  task automatic drain_block();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input tol_t t);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    filter_sb.set_tolerance(t);
  endtask

  // smooth track with occasional spikes and over-range samples, or plain noise
  task automatic send_block(input int len, input bit noisy);
    int base, a;
    base = $urandom_range(0, 359);
    for (int i = 0; i < len; i++) begin
      if (sent_count == pause_at) wait_for_results();
      base = (base + 360 + int'($urandom_range(0, 16)) - 8) % 360;
      if (noisy) a = $urandom_range(0, 511);
      else if ($urandom_range(0, 5) == 0)
        a = $urandom_range(0, 1) ? (base + 90 + int'($urandom_range(0, 180))) % 360
                                 : int'($urandom_range(360, 511));
      else a = base;
      send_sample(aorf_pkg::angle_t'(a), i == len - 1);
    end
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    int r;
    bit long_hold_done;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        filter_sb.check_result(out_angle_out, out_replaced, out_last_out);
      if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) hold_left = $urandom_range(8, 25);
        out_stall <= (r < 25);
      end
    end
  end

  initial begin
    int dir_angles[24];
    bit dir_last[24];
    int len, phase_items;
    tol_t t;

    // lone over-range sample; short pass-through block; minimal full block; longer block
    dir_angles = '{511,
                   0, 359, 180, 100, 300, 0,
                   200, 10, 12, 355, 5, 90, 8,
                   100, 102, 300, 104, 106, 108, 400, 110, 112, 0};
    dir_last = '{1,
                 0, 0, 0, 0, 0, 1,
                 0, 0, 0, 0, 0, 0, 1,
                 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 24; i++) send_sample(aorf_pkg::angle_t'(dir_angles[i]), dir_last[i]);
    drain_block();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: t = 8'd0;
        1: t = 8'd255;
        2: t = 8'd179;
        3: t = 8'd180;
        4: t = tol_t'($urandom_range(1, 60));
        default: t = tol_t'($urandom_range(0, 255));
      endcase
      write_tolerance(t);
      quiet = (p == 4);
      if (p == 2) pause_at = sent_count + 6;
      phase_items = 0;
      while (phase_items < 10) begin
        if (p == 1) len = $urandom_range(12, 25);
        else if ($urandom_range(0, 4) == 0) len = $urandom_range(1, 6);
        else len = $urandom_range(7, 16);
        send_block(len, $urandom_range(0, 4) == 0);
        phase_items += len;
      end
      drain_block();
    end
    quiet = 1'b0;

    if (filter_sb.pending_results.size() != 0)
      filter_sb.report_mismatch("results still owed", filter_sb.pending_results.size(), 0);
    if (filter_sb.errors == 0) begin
      $display("[angle_outlier_replace_filter] OK");
    end else begin
      $display("[angle_outlier_replace_filter] ERROR");
    end
    $finish;
  end

endmodule
